// ===== hw/rtl/asc_pkg.sv =====
// Shared types, codes and constants for the accelerometer step counter.
// Used by asc_ctrl, asc_datapath and accel_step_counter; depends on nothing.
package asc_pkg;

   localparam int unsigned CAL_SAMPLES = 100;
   localparam logic [15:0] IDLE_MAGNITUDE_RESET = 16'd16472;
   localparam logic [15:0] FAULT_MARGIN_RESET = 16'd50;

   localparam logic [16:0] CAL_OPERAND = 17'(CAL_SAMPLES);
   localparam logic [7:0] CAL_COUNT_LIMIT = 8'(CAL_SAMPLES);

   // ceil(2^RECIP_SHIFT / CAL_SAMPLES): exact quotient for any 23-bit dividend
   localparam int unsigned RECIP_SHIFT = 30;
   localparam logic [30:0] CAL_RECIP =
      31'(((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

   localparam int unsigned CNT_W = 5;
   localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(3);
   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(15);

   localparam logic CSR_IDLE_MAGNITUDE = 1'b0;
   localparam logic CSR_FAULT_MARGIN = 1'b1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      PHASE_CAL = 2'd0,
      PHASE_COUNT = 2'd1,
      PHASE_FAULT = 2'd2
   } asc_phase_type;

   typedef enum logic [2:0] {
      MUL_X,
      MUL_Y,
      MUL_Z,
      MUL_IDLE,
      MUL_FAULT
   } asc_mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_UPDATE,
      ST_CAL_MUL_IDLE,
      ST_CAL_MUL_FAULT,
      ST_CAL_DIFF,
      ST_CAL_END,
      ST_EMIT
   } asc_state_type;

   typedef struct packed {
      logic        op;
      logic [15:0] accel_x;
      logic [15:0] accel_y;
      logic [15:0] accel_z;
   } asc_req_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [15:0] steps;
      logic        step_taken;
      logic [15:0] magnitude;
      logic [16:0] magnitude_change;
      logic [15:0] step_threshold;
   } asc_rsp_type;

   typedef struct packed {
      logic            load;
      logic            sq_step;
      logic            sq_first;
      asc_mul_sel_type mul_sel;
      logic            root_step;
      logic            update;
      logic            diff_load;
      logic            div_init;
      logic            cal_finish;
      logic            out_load;
   } asc_cmd_type;

   typedef struct packed {
      logic          op;
      logic          cal_end;
      asc_phase_type phase;
   } asc_status_type;

endpackage

// ===== hw/rtl/asc_ctrl.sv =====
// Sequencer for the step counter: walks each sample word through square, root, update
// and the end-of-calibration divide; a clear word only updates. Depends on asc_pkg.
module asc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  asc_pkg::asc_status_type status,
   output asc_pkg::asc_cmd_type    cmd
);
   import asc_pkg::*;

   asc_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             can_emit;

   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_CLEAR) ? ST_UPDATE : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (cnt_ff == SQ_LAST) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (cnt_ff == ROOT_LAST) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = status.cal_end ? ST_CAL_MUL_IDLE : ST_EMIT;
         end
         ST_CAL_MUL_IDLE:  state_in = ST_CAL_MUL_FAULT;
         ST_CAL_MUL_FAULT: state_in = ST_CAL_DIFF;
         ST_CAL_DIFF:      state_in = ST_CAL_END;
         ST_CAL_END:       state_in = ST_EMIT;
         ST_EMIT: begin
            if (can_emit) state_in = ST_IDLE;
         end
         default:          state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_X;
      cnt_in = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
         end
         ST_SQUARE: begin
            cmd.sq_step = 1'b1;
            cmd.sq_first = (cnt_ff == '0);
            unique case (cnt_ff[1:0])
               2'd0:    cmd.mul_sel = MUL_X;
               2'd1:    cmd.mul_sel = MUL_Y;
               default: cmd.mul_sel = MUL_Z;
            endcase
            cnt_in = (cnt_ff == SQ_LAST) ? '0 : cnt_ff + 1'b1;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in = (cnt_ff == ROOT_LAST) ? '0 : cnt_ff + 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_CAL_MUL_IDLE: begin
            cmd.mul_sel = MUL_IDLE;
         end
         ST_CAL_MUL_FAULT: begin
            cmd.mul_sel = MUL_FAULT;
            cmd.diff_load = 1'b1;
         end
         ST_CAL_DIFF: begin
            cmd.div_init = 1'b1;
         end
         ST_CAL_END: begin
            cmd.cal_finish = 1'b1;
         end
         ST_EMIT: begin
            if (can_emit) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/asc_datapath.sv =====
// Datapath for the step counter: shared multiplier, bit-serial square root,
// calibration divider, step state and the result register. Depends on asc_pkg.
module asc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  asc_pkg::asc_req_type    req_data,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [15:0]             csr_wdata,
   input  asc_pkg::asc_cmd_type    cmd,
   output asc_pkg::asc_status_type status,
   output asc_pkg::asc_rsp_type    rsp_data
);
   import asc_pkg::*;

   // configuration
   logic [15:0]          idle_ff, fault_ff;
   // captured word
   logic                 op_ff;
   logic signed [15:0]   ax_ff, ay_ff, az_ff;
   // arithmetic
   logic [31:0]          prod_ff, acc_ff, root_ff, bit_ff;
   logic [31:0]          acc_in, root_in, bit_in;
   logic signed [16:0]   mul_a, mul_b;
   logic signed [33:0]   mul_p;
   logic [31:0]          trial;
   logic signed [24:0]   diff_ff, diff_in;
   logic signed [24:0]   diff_abs;
   logic                 fault_flag_ff;
   logic [53:0]          recip_ff;
   // step state
   asc_phase_type        phase_ff, phase_in;
   logic [6:0]           calib_count_ff, calib_count_in;
   logic [22:0]          calib_sum_ff, calib_sum_in;
   logic [15:0]          threshold_ff, threshold_in;
   logic [15:0]          prev_mag_ff, prev_mag_in;
   logic [15:0]          steps_ff, steps_in;
   // per-word results
   logic [15:0]          mag_ff, mag_in, mag;
   logic [16:0]          change_ff, change_in;
   logic                 taken_ff, taken_in;
   logic [15:0]          abs_change;
   asc_rsp_type          rsp_ff;

   assign mag = root_ff[15:0];
   assign rsp_data = rsp_ff;

   assign status.op = op_ff;
   assign status.phase = phase_ff;
   assign status.cal_end = (phase_ff == PHASE_CAL) && (op_ff == OP_SAMPLE)
                           && ({1'b0, calib_count_ff} + 8'd1 >= CAL_COUNT_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= IDLE_MAGNITUDE_RESET;
         fault_ff <= FAULT_MARGIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IDLE_MAGNITUDE: idle_ff <= csr_wdata;
            CSR_FAULT_MARGIN:   fault_ff <= csr_wdata;
            default:            idle_ff <= idle_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_data.op;
         ax_ff <= signed'(req_data.accel_x);
         ay_ff <= signed'(req_data.accel_y);
         az_ff <= signed'(req_data.accel_z);
      end
   end

   // shared 17x17 multiplier, registered
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_X: begin
            mul_a = {ax_ff[15], ax_ff};
            mul_b = {ax_ff[15], ax_ff};
         end
         MUL_Y: begin
            mul_a = {ay_ff[15], ay_ff};
            mul_b = {ay_ff[15], ay_ff};
         end
         MUL_Z: begin
            mul_a = {az_ff[15], az_ff};
            mul_b = {az_ff[15], az_ff};
         end
         MUL_IDLE: begin
            mul_a = signed'({1'b0, idle_ff});
            mul_b = signed'(CAL_OPERAND);
         end
         MUL_FAULT: begin
            mul_a = signed'({1'b0, fault_ff});
            mul_b = signed'(CAL_OPERAND);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p[31:0];
   end

   // sum of squares, then remainder of the bit-serial root
   always_comb begin
      acc_in = acc_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      trial = root_ff + bit_ff;
      if (cmd.sq_step) begin
         acc_in = cmd.sq_first ? '0 : acc_ff + prod_ff;
         root_in = '0;
         bit_in = 32'h4000_0000;
      end else if (cmd.root_step) begin
         if (acc_ff >= trial) begin
            acc_in = acc_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end else if (cmd.load) begin
         root_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
   end

   // calibration: difference, fault check and divide by the sample count
   // through a reciprocal multiply
   assign diff_in = signed'({2'b00, calib_sum_ff}) - signed'({2'b00, prod_ff[22:0]});
   assign diff_abs = diff_ff[24] ? -diff_ff : diff_ff;

   always_ff @(posedge clock) begin
      if (cmd.diff_load) diff_ff <= diff_in;
      if (cmd.div_init) begin
         fault_flag_ff <= (diff_ff <= signed'({2'b00, prod_ff[22:0]}));
         recip_ff <= 54'(diff_abs[22:0]) * 54'(CAL_RECIP);
      end
   end

   // step state update
   assign abs_change = (mag >= prev_mag_ff) ? mag - prev_mag_ff : prev_mag_ff - mag;

   always_comb begin
      phase_in = phase_ff;
      calib_count_in = calib_count_ff;
      calib_sum_in = calib_sum_ff;
      threshold_in = threshold_ff;
      prev_mag_in = prev_mag_ff;
      steps_in = steps_ff;
      mag_in = mag_ff;
      change_in = change_ff;
      taken_in = taken_ff;
      if (cmd.update) begin
         mag_in = '0;
         change_in = '0;
         taken_in = 1'b0;
         if (op_ff == OP_CLEAR) begin
            if (phase_ff == PHASE_COUNT) steps_in = '0;
         end else begin
            mag_in = mag;
            unique case (phase_ff)
               PHASE_CAL: begin
                  calib_sum_in = calib_sum_ff + 23'(mag);
                  calib_count_in = calib_count_ff + 7'd1;
               end
               PHASE_COUNT: begin
                  change_in = {1'b0, mag} - {1'b0, prev_mag_ff};
                  if (abs_change > threshold_ff) begin
                     taken_in = 1'b1;
                     steps_in = steps_ff + 16'd1;
                  end
                  prev_mag_in = mag;
               end
               default: begin
                  mag_in = mag;
               end
            endcase
         end
      end else if (cmd.cal_finish) begin
         threshold_in = recip_ff[RECIP_SHIFT +: 16];
         phase_in = fault_flag_ff ? PHASE_FAULT : PHASE_COUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_CAL;
         calib_count_ff <= '0;
         calib_sum_ff <= '0;
         threshold_ff <= '0;
         prev_mag_ff <= '0;
         steps_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         calib_count_ff <= calib_count_in;
         calib_sum_ff <= calib_sum_in;
         threshold_ff <= threshold_in;
         prev_mag_ff <= prev_mag_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      change_ff <= change_in;
      taken_ff <= taken_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.phase <= phase_ff;
         rsp_ff.steps <= steps_ff;
         rsp_ff.step_taken <= taken_ff;
         rsp_ff.magnitude <= mag_ff;
         rsp_ff.magnitude_change <= change_ff;
         rsp_ff.step_threshold <= threshold_ff;
      end
   end

endmodule

// ===== hw/rtl/accel_step_counter.sv =====
// Top level of the accelerometer step counter: controller plus datapath.
// Depends on asc_pkg, asc_ctrl and asc_datapath.
//
//   channel  handshake              payload
//   req      req_valid / req_ready  req_data  (asc_req_type)
//   rsp      rsp_valid / rsp_ready  rsp_data  (asc_rsp_type)
//   csr      csr_valid / csr_ready  csr_index, csr_wdata
//
// A sample word is squared one axis at a time on the shared multiplier, then
// goes through the one-bit-per-cycle square root, the update and the emit state.
// A clear word goes through the update and emit states; the last calibration
// sample adds the difference, fault check and reciprocal divide by the sample count.
// One word is in flight at a time.
// The next word is taken while a result waits in the output register.
// Reset is synchronous; csr writes are always taken.
module accel_step_counter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  asc_pkg::asc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output asc_pkg::asc_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata
);
   import asc_pkg::*;

   asc_cmd_type    cmd;
   asc_status_type status;

   assign csr_ready = 1'b1;

   asc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   asc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while another is in flight");

   a_fault_sticks: assert property (@(posedge clock) disable iff (reset)
      status.phase == PHASE_FAULT |=> status.phase == PHASE_FAULT)
      else $error("left calibration fault without reset");

   a_no_threshold_in_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase == PHASE_CAL |-> rsp_data.step_threshold == '0)
      else $error("threshold reported before calibration ended");

   a_step_only_counting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_taken |-> rsp_data.phase == PHASE_COUNT)
      else $error("step taken outside counting phase");

endmodule
